@@ rtl/core/sdd_pkg.sv @@
// Shared widths, flag bundle and helpers for the serpentine dither core.
`timescale 1ns / 1ps

package sdd_pkg;

	localparam int PIX_W = 8;   // source channel width
	localparam int Q_W   = 5;   // quantized channel width
	localparam int POS_W = 9;   // reported position width
	localparam int IDX_W = 7;   // source load index width
	localparam int E_W   = 4;   // one quantization error, -7..7
	localparam int ERR_W = 7;   // stored next-row error, -63..63 in 16ths
	localparam int ACC_W = 9;   // carried error plus forward share, -112..112

	localparam int LANES = 3;

	// Stream data widths.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic first;  // first pixel of a display row
		logic row0;   // first display row of the image
		logic last;   // final pixel of the image
	} pix_flags_t;

	function automatic int addr_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

@@ rtl/core/sdd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sdd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/sdd_scan.sv @@
// Serpentine scan counters: display position, source column and row flags.
`timescale 1ns / 1ps

module sdd_scan #(
	parameter int DISPLAY_WIDTH  = 384,
	parameter int DISPLAY_HEIGHT = 384,
	parameter int SOURCE_WIDTH   = 128,
	parameter int SCALE          = 3,
	parameter int CW             = $clog2(DISPLAY_WIDTH),
	parameter int RW             = $clog2(DISPLAY_HEIGHT),
	parameter int SA_W           = (SOURCE_WIDTH > 1) ? $clog2(SOURCE_WIDTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	output logic [CW-1:0]       pos_x,
	output logic [RW-1:0]       pos_y,
	output logic [SA_W-1:0]     src_col,
	output sdd_pkg::pix_flags_t flags
);

	import sdd_pkg::*;

	localparam int SBW      = (SCALE > 1) ? $clog2(SCALE) : 1;
	localparam int SX_LAST  = (DISPLAY_WIDTH - 1) / SCALE;
	localparam int SUB_LAST = (DISPLAY_WIDTH - 1) % SCALE;

	logic [CW-1:0]  k_q, x_q, sx_q;
	logic [RW-1:0]  y_q;
	logic [SBW-1:0] sub_q;
	logic           row_end, img_end;
	logic [RW-1:0]  y_next;

	assign row_end = (k_q == CW'(DISPLAY_WIDTH - 1));
	assign img_end = row_end && (y_q == RW'(DISPLAY_HEIGHT - 1));
	assign y_next  = (y_q == RW'(DISPLAY_HEIGHT - 1)) ? '0 : y_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			y_q   <= '0;
			x_q   <= '0;
			sx_q  <= '0;
			sub_q <= '0;
		end else if (step) begin
			if (row_end) begin
				k_q <= '0;
				y_q <= y_next;
				// Odd rows start at the right edge and walk left.
				if (y_next[0]) begin
					x_q   <= CW'(DISPLAY_WIDTH - 1);
					sx_q  <= CW'(SX_LAST);
					sub_q <= SBW'(SUB_LAST);
				end else begin
					x_q   <= '0;
					sx_q  <= '0;
					sub_q <= '0;
				end
			end else begin
				k_q <= k_q + 1'b1;
				if (!y_q[0]) begin
					x_q <= x_q + 1'b1;
					if (sub_q == SBW'(SCALE - 1)) begin
						sub_q <= '0;
						sx_q  <= sx_q + 1'b1;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end else begin
					x_q <= x_q - 1'b1;
					if (sub_q == '0) begin
						sub_q <= SBW'(SCALE - 1);
						sx_q  <= sx_q - 1'b1;
					end else begin
						sub_q <= sub_q - 1'b1;
					end
				end
			end
		end
	end

	assign pos_x = x_q;
	assign pos_y = y_q;

	always_comb begin
		if ({1'b0, sx_q} >= (CW + 1)'(SOURCE_WIDTH)) begin
			src_col = SA_W'(SOURCE_WIDTH - 1);
		end else begin
			src_col = sx_q[SA_W-1:0];
		end
	end

	assign flags.first = (k_q == '0);
	assign flags.row0  = (y_q == '0);
	assign flags.last  = img_end;

endmodule

@@ rtl/core/sdd_lane.sv @@
// One color lane: carried error, rounding, clamp, 5-bit quantize and error spread.
`timescale 1ns / 1ps

module sdd_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              first,
	input  logic                              row0,
	input  logic [sdd_pkg::PIX_W-1:0]         src,
	input  logic signed [sdd_pkg::ERR_W-1:0]  base_rd,
	output logic [sdd_pkg::Q_W-1:0]           q5,
	output logic signed [sdd_pkg::ERR_W-1:0]  wr_err
);

	import sdd_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_HALF = 8;
	localparam logic signed [ACC_W:0]   V_MAX    = 255;

	logic signed [E_W-1:0]   e_prev_q, e_eff, e;
	logic signed [ERR_W-1:0] p1_q, base, p1_next, e_w, ep_w;
	logic signed [ACC_W-1:0] acc, e_ext, rnd;
	logic signed [ACC_W:0]   sv;
	logic [PIX_W-1:0]        v;

	always_comb begin
		e_eff = first ? '0 : e_prev_q;
		// Row 0 sees a cleared error line; a row's first pixel takes the value the
		// previous row left for its last column, which never went to the line RAM.
		if (row0) begin
			base = '0;
		end else if (first) begin
			base = p1_q;
		end else begin
			base = base_rd;
		end
		e_ext = ACC_W'(e_eff);
		acc   = ACC_W'(base) + (e_ext <<< 3) - e_ext;
		rnd   = (acc + RND_HALF) >>> 4;
		sv    = $signed({2'b00, src}) + (ACC_W + 1)'(rnd);
		if (sv[ACC_W]) begin
			v = '0;
		end else if (sv > V_MAX) begin
			v = '1;
		end else begin
			v = sv[PIX_W-1:0];
		end
		q5 = v[PIX_W-1:PIX_W-Q_W];
		// Error against the exact reconstruction {q5, q5[4:2]}.
		e = $signed({1'b0, v[2:0]}) - $signed({1'b0, v[PIX_W-1:PIX_W-3]});
		e_w  = ERR_W'(e);
		ep_w = ERR_W'(e_eff);
		// Entry behind is complete once this pixel adds its 3/16 share.
		wr_err  = p1_q + (e_w <<< 1) + e_w;
		p1_next = ep_w + (e_w <<< 2) + e_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_prev_q <= '0;
			p1_q     <= '0;
		end else if (adv) begin
			e_prev_q <= e;
			p1_q     <= p1_next;
		end
	end

endmodule

@@ rtl/core/serpentine_error_diffusion_dither.sv @@
// Top level of the serpentine Floyd-Steinberg dither with 5-bit RGB output.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: op; tdata: src_index, red_in, green_in, blue_in
// m_axis    out        tdata: pos_x, pos_y, red_q, green_q, blue_q; tlast: image_done
//
// One beat per clock in both directions while the output is not stalled; a pixel
// beat's result passes the lane stage and then the output register. The line RAM and
// source RAM reads are registered, and the error of each pixel feeds the next through one stage of lane logic.
// Reset clears the scan counters and pipeline valids; RAM contents are not cleared.
// A stalled output holds the lane stage, and the input is stalled only while
// that stage is full and cannot drain.
`timescale 1ns / 1ps

module serpentine_error_diffusion_dither #(
	parameter int DISPLAY_WIDTH  = 384,
	parameter int DISPLAY_HEIGHT = 384,
	parameter int SOURCE_WIDTH   = 128,
	parameter int SCALE          = 3,
	parameter int CHANNELS       = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// src_index[6:0], red_in[14:7], green_in[22:15], blue_in[30:23], zero[31]
	input  logic [sdd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// op[0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pos_x[8:0], pos_y[17:9], red_q[22:18], green_q[27:23], blue_q[32:28], zero[39:33]
	output logic [sdd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tlast
);

	import sdd_pkg::*;

	localparam int CW    = $clog2(DISPLAY_WIDTH);
	localparam int RW    = $clog2(DISPLAY_HEIGHT);
	localparam int SA_W  = addr_width(SOURCE_WIDTH);
	localparam int SRC_W = LANES * PIX_W;
	localparam int LN_W  = CHANNELS * ERR_W;
	localparam int IX_W  = 10;

	logic in_acc, pix_acc, ld_acc, out_free, adv;

	// Scan position of the beat at the input.
	logic [CW-1:0]   scan_x;
	logic [RW-1:0]   scan_y;
	logic [SA_W-1:0] scan_sx;
	pix_flags_t      scan_flags;

	// Lane stage.
	logic            valid_s1;
	logic [CW-1:0]   x_s1;
	logic [RW-1:0]   y_s1;
	pix_flags_t      flags_s1;
	logic [CW-1:0]   xprev_q;

	logic [SRC_W-1:0] src_rdata;
	logic [LN_W-1:0]  line_rdata, line_wdata;
	logic [IX_W-1:0]  ld_idx;
	logic             ld_ok;

	logic [Q_W-1:0] q_lane [LANES];

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_last_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign pix_acc       = in_acc && s_axis_tuser;
	assign ld_acc        = in_acc && !s_axis_tuser;

	assign ld_idx = IX_W'(s_axis_tdata[IDX_W-1:0]);
	assign ld_ok  = (ld_idx < IX_W'(SOURCE_WIDTH));

	sdd_scan #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT),
		.SOURCE_WIDTH   (SOURCE_WIDTH),
		.SCALE          (SCALE),
		.CW             (CW),
		.RW             (RW),
		.SA_W           (SA_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (pix_acc),
		.pos_x   (scan_x),
		.pos_y   (scan_y),
		.src_col (scan_sx),
		.flags   (scan_flags)
	);

	// Source row buffer, red in the top byte.
	sdd_ram #(
		.WIDTH (SRC_W),
		.DEPTH (SOURCE_WIDTH),
		.AW    (SA_W)
	) u_src_ram (
		.clk   (clk),
		.we    (ld_acc && ld_ok),
		.waddr (ld_idx[SA_W-1:0]),
		.wdata ({s_axis_tdata[14:7], s_axis_tdata[22:15], s_axis_tdata[30:23]}),
		.re    (pix_acc),
		.raddr (scan_sx),
		.rdata (src_rdata)
	);

	// One error line: each column is read by this row and then overwritten
	// with the share for the next row once the pixel after it is done.
	sdd_ram #(
		.WIDTH (LN_W),
		.DEPTH (DISPLAY_WIDTH),
		.AW    (CW)
	) u_line_ram (
		.clk   (clk),
		.we    (adv && !flags_s1.first),
		.waddr (xprev_q),
		.wdata (line_wdata),
		.re    (pix_acc),
		.raddr (scan_x),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			x_s1     <= scan_x;
			y_s1     <= scan_y;
			flags_s1 <= scan_flags;
		end
		if (adv) begin
			xprev_q <= x_s1;
		end
	end

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			sdd_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.first   (flags_s1.first),
				.row0    (flags_s1.row0),
				.src     (src_rdata[SRC_W-1-c*PIX_W -: PIX_W]),
				.base_rd (line_rdata[c*ERR_W +: ERR_W]),
				.q5      (q_lane[c]),
				.wr_err  (line_wdata[c*ERR_W +: ERR_W])
			);
		end else begin : g_off
			assign q_lane[c] = '0;
		end
	end

	// Merge the lanes into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {7'd0, q_lane[2], q_lane[1], q_lane[0],
				POS_W'(y_s1), POS_W'(x_s1)};
			m_last_q <= flags_s1.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

@@ test/dither_monitor.sv @@
// Scan-order predictor and result comparison for the serpentine dither testbench.
`timescale 1ns / 1ps

package dither_tb_pkg;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_DITHER = 1'b1
	} dither_op_e;

endpackage

module dither_monitor #(
	parameter int DISPLAY_WIDTH  = 384,
	parameter int DISPLAY_HEIGHT = 384,
	parameter int SOURCE_WIDTH   = 128,
	parameter int SCALE          = 3,
	parameter int CHANNELS       = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [sdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [sdd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           m_axis_tlast,
	output int                             mismatches,
	output int                             waiting,
	output int                             pixels_checked,
	output int                             images_done
);
	import sdd_pkg::*;
	import dither_tb_pkg::*;

	localparam int ERR_COLS   = DISPLAY_WIDTH + 2;
	localparam int SRC_DEPTH  = 1 << IDX_W;
	localparam int PIX_MAX    = (1 << PIX_W) - 1;
	localparam int REPORT_CAP = 40;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [Q_W-1:0]   red;
		logic [Q_W-1:0]   green;
		logic [Q_W-1:0]   blue;
		logic             done;
	} pixel_result_t;

	logic [3*PIX_W-1:0] src_line [SRC_DEPTH];
	int                 err_line [2][ERR_COLS][LANES];
	int                 col_step;
	int                 row_idx;
	pixel_result_t      pending_pixels [$];

	function automatic void clear_err_row(input int r);
		for (int c = 0; c < ERR_COLS; c++)
			for (int ch = 0; ch < LANES; ch++)
				err_line[r][c][ch] = 0;
	endfunction

	function automatic pixel_result_t dither_next_pixel();
		pixel_result_t res;
		int odd, x, sx, col, ahead, behind, s, acc, v, q5, e;
		logic [3*PIX_W-1:0] pix;
		res = '0;
		odd = row_idx % 2;
		if (col_step == 0) begin
			if (row_idx == 0)
				clear_err_row(0);
			clear_err_row(1 - odd);
		end
		x = odd ? DISPLAY_WIDTH - 1 - col_step : col_step;
		sx = x / SCALE;
		if (sx >= SOURCE_WIDTH)
			sx = SOURCE_WIDTH - 1;
		if (sx >= SRC_DEPTH)
			sx = SRC_DEPTH - 1;
		pix = src_line[sx];
		// Error cells are offset by one so that both edges have a slack cell.
		col = x + 1;
		ahead = odd ? col - 1 : col + 1;
		behind = odd ? col + 1 : col - 1;
		for (int ch = 0; ch < CHANNELS && ch < LANES; ch++) begin
			s = int'(pix[2*PIX_W - PIX_W*ch +: PIX_W]);
			acc = err_line[odd][col][ch];
			// Carried error is in sixteenths; round half up, then saturate.
			v = s + ((acc + 8) >>> 4);
			if (v < 0)
				v = 0;
			else if (v > PIX_MAX)
				v = PIX_MAX;
			q5 = v >> (PIX_W - Q_W);
			e = v - ((q5 << (PIX_W - Q_W)) | (q5 >> (2*Q_W - PIX_W)));
			err_line[odd][ahead][ch] += 7 * e;
			err_line[1 - odd][behind][ch] += 3 * e;
			err_line[1 - odd][col][ch] += 5 * e;
			err_line[1 - odd][ahead][ch] += e;
			case (ch)
				0: res.red = Q_W'(q5);
				1: res.green = Q_W'(q5);
				default: res.blue = Q_W'(q5);
			endcase
		end
		res.x = POS_W'(x);
		res.y = POS_W'(row_idx);
		col_step++;
		if (col_step >= DISPLAY_WIDTH) begin
			col_step = 0;
			row_idx++;
			if (row_idx >= DISPLAY_HEIGHT) begin
				row_idx = 0;
				res.done = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic void compare_field(input string name, input int want_v, input int got_v,
			input pixel_result_t at);
		if (want_v != got_v) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s at x=%0d y=%0d expected %0d, actual %0d",
					$time, name, at.x, at.y, want_v, got_v);
		end
	endfunction

	function automatic void check_result();
		pixel_result_t want;
		if (pending_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: result beat with no pixel pending, expected none, actual %h",
					$time, m_axis_tdata);
			return;
		end
		want = pending_pixels.pop_front();
		compare_field("pos_x", int'(want.x), int'(m_axis_tdata[0 +: POS_W]), want);
		compare_field("pos_y", int'(want.y), int'(m_axis_tdata[POS_W +: POS_W]), want);
		compare_field("red_q", int'(want.red), int'(m_axis_tdata[2*POS_W +: Q_W]), want);
		compare_field("green_q", int'(want.green),
			int'(m_axis_tdata[2*POS_W + Q_W +: Q_W]), want);
		compare_field("blue_q", int'(want.blue),
			int'(m_axis_tdata[2*POS_W + 2*Q_W +: Q_W]), want);
		compare_field("image_done", int'(want.done), int'(m_axis_tlast), want);
		pixels_checked++;
		if (m_axis_tlast)
			images_done++;
	endfunction

	function automatic void take_beat();
		int idx;
		idx = int'(s_axis_tdata[IDX_W-1:0]);
		if (s_axis_tuser == OP_DITHER) begin
			pending_pixels.push_back(dither_next_pixel());
		end else if (idx < SOURCE_WIDTH && idx < SRC_DEPTH) begin
			src_line[idx] = {s_axis_tdata[IDX_W +: PIX_W], s_axis_tdata[IDX_W + PIX_W +: PIX_W],
				s_axis_tdata[IDX_W + 2*PIX_W +: PIX_W]};
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step = 0;
			row_idx = 0;
			clear_err_row(0);
			clear_err_row(1);
			pending_pixels.delete();
			mismatches = 0;
			pixels_checked = 0;
			images_done = 0;
		end else begin
			// Results trail their pixel beats, so retire before predicting.
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				take_beat();
		end
		waiting = pending_pixels.size();
	end

endmodule

@@ test/tb.sv @@
// Testbench top for the serpentine dither: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
	import sdd_pkg::*;
	import dither_tb_pkg::*;

	localparam int DISP_W       = 384;
	localparam int DISP_H       = 384;
	localparam int SRC_W        = 128;
	localparam int SCALE        = 3;
	localparam int CHANNELS     = 3;
	localparam int PHASE_ITEMS  = 200;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int         mismatches;
	int         waiting;
	int         pixels_checked;
	int         images_done;
	idle_mode_e idle_mode = IDLE_NONE;
	bit         hold_request = 1'b0;
	int         gen_col = 0;
	int         gen_row = 0;
	int         loads_sent = 0;
	bit         written [SRC_W];

	serpentine_error_diffusion_dither #(
		.DISPLAY_WIDTH(DISP_W), .DISPLAY_HEIGHT(DISP_H), .SOURCE_WIDTH(SRC_W),
		.SCALE(SCALE), .CHANNELS(CHANNELS)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	dither_monitor #(
		.DISPLAY_WIDTH(DISP_W), .DISPLAY_HEIGHT(DISP_H), .SOURCE_WIDTH(SRC_W),
		.SCALE(SCALE), .CHANNELS(CHANNELS)
	) mon (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.mismatches(mismatches), .waiting(waiting),
		.pixels_checked(pixels_checked), .images_done(images_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d pixel results still outstanding", waiting);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned gap_pct();
		case (idle_mode)
			IDLE_SENDER: return 77;
			IDLE_BOTH:   return 12;
			default:     return 0;
		endcase
	endfunction

	function automatic int unsigned stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 77;
			IDLE_BOTH:     return 12;
			default:       return 0;
		endcase
	endfunction

	// Levels near black and white make the clamps and large errors common.
	function automatic logic [PIX_W-1:0] pick_level();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 8'($urandom_range(0, 7));
			3: return 8'($urandom_range(248, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_beat(input dither_op_e op, input int idx,
			input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		logic [IN_DATA_W-1:0] beat;
		beat = '0;
		beat[IDX_W-1:0] = idx[IDX_W-1:0];
		beat[IDX_W +: PIX_W] = r;
		beat[IDX_W + PIX_W +: PIX_W] = g;
		beat[IDX_W + 2*PIX_W +: PIX_W] = b;
		while ($urandom_range(99) < gap_pct()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic load_entry(input int idx, input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		send_beat(OP_LOAD, idx, r, g, b);
		if (idx < SRC_W)
			written[idx] = 1'b1;
		loads_sent++;
	endtask

	// An odd stride walks the whole power-of-two row in a scrambled order.
	task automatic reload_row();
		int stride, start;
		stride = 2 * $urandom_range(63) + 1;
		start = $urandom_range(SRC_W - 1);
		for (int i = 0; i < SRC_W; i++)
			load_entry((start + i * stride) % SRC_W, pick_level(), pick_level(), pick_level());
	endtask

	task automatic dither_one(output bit wrapped);
		int x, sx;
		x = (gen_row % 2) ? DISP_W - 1 - gen_col : gen_col;
		sx = x / SCALE;
		if (sx >= SRC_W)
			sx = SRC_W - 1;
		// Never let the block read a source entry that has not been loaded.
		if (!written[sx])
			load_entry(sx, pick_level(), pick_level(), pick_level());
		send_beat(OP_DITHER, $urandom_range(SRC_W - 1), 8'($urandom), 8'($urandom),
			8'($urandom));
		wrapped = 1'b0;
		gen_col++;
		if (gen_col == DISP_W) begin
			gen_col = 0;
			gen_row++;
			if (gen_row == DISP_H) begin
				gen_row = 0;
				wrapped = 1'b1;
			end
		end
	endtask

	task automatic random_step(output bit wrapped);
		wrapped = 1'b0;
		if ($urandom_range(99) < 6) begin
			load_entry($urandom_range((1 << IDX_W) - 1), pick_level(), pick_level(),
				pick_level());
		end else begin
			if (gen_col == 0 && gen_row % SCALE == 0)
				reload_row();
			dither_one(wrapped);
		end
	endtask

	task automatic run_items(input int count);
		bit wrapped;
		repeat (count)
			random_step(wrapped);
	endtask

	initial begin : output_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !($urandom_range(99) < stall_pct());
			end
		end
	end

	initial begin : stimulus
		bit wrapped;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed start of the first image: extreme levels in the first and last source columns.
		load_entry(0, 8'd0, 8'd255, 8'd7);
		load_entry(1, 8'd255, 8'd0, 8'd248);
		load_entry(2, 8'd128, 8'd127, 8'd1);
		load_entry(SRC_W - 1, 8'd255, 8'd255, 8'd255);
		repeat (3 * SCALE)
			dither_one(wrapped);
		load_entry(SRC_W - 1, 8'd0, 8'd0, 8'd0);
		load_entry(0, 8'd255, 8'd255, 8'd255);
		repeat (3)
			dither_one(wrapped);

		idle_mode = IDLE_NONE;
		run_items(PHASE_ITEMS);
		idle_mode = IDLE_SENDER;
		run_items(PHASE_ITEMS);
		idle_mode = IDLE_RECEIVER;
		run_items(PHASE_ITEMS);
		// Output held off while beats keep coming, so the input must back up.
		idle_mode = IDLE_NONE;
		hold_request = 1'b1;
		run_items(PHASE_ITEMS / 2);
		idle_mode = IDLE_BOTH;
		run_items(PHASE_ITEMS);

		// A last burst at full rate.
		idle_mode = IDLE_NONE;
		run_items(40);
		s_axis_tvalid <= 1'b0;

		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d dithered pixels over %0d image end(s), %0d source loads, %0d mismatches.",
			pixels_checked, images_done, loads_sent, mismatches);
		$display("Flow phases: free running, sender gaps, receiver stalls, both, long hold-off.");
		if (mismatches == 0 && waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
